// File: rtl/tpi_pkg.sv
// Shared types, widths and codes for the three-plane intersection block.
// Used by tpi_front, tpi_divider, three_plane_intersection and tpi_checker.
package tpi_pkg;

    // Input coefficient width, Q11.12.
    localparam int NW = 24;
    // Product of two coefficients.
    localparam int PW = 2 * NW;
    // Cross product component.
    localparam int CW = PW + 1;
    // Split of a cross product component for the second multiply.
    localparam int LW = 25;
    localparam int HW = CW - LW;
    // Width of a low partial product (signed by unsigned).
    localparam int LPW = NW + LW + 1;
    // One recombined term of a triple or numerator sum.
    localparam int TW = NW + CW;
    // Sum of three terms and its magnitude.
    localparam int SW = TW + 2;
    localparam int MW = SW - 1;
    // Quotient bits kept by the divider and the fraction shift.
    localparam int QW = 33;
    localparam int FRAC_SHIFT = 16;
    localparam int PRE_SHIFT = QW - FRAC_SHIFT;
    // Output coordinate and limit register widths.
    localparam int OW = 32;
    localparam int LIMW = 32;

    // Cycles from an accepted word to its result strobe.
    localparam int FRONT_STAGES = 6;
    localparam int LATENCY = FRONT_STAGES + 1 + QW + 1;

    localparam logic [LIMW-1:0] LIMIT_RESET = 32'd69;
    localparam logic [OW-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [OW-1:0] SAT_NEG = 32'h8000_0000;
    localparam logic [QW-1:0] QMAX_POS = 33'h0_7FFF_FFFF;
    localparam logic [QW-1:0] QMAX_NEG = 33'h0_8000_0000;

    // Result status codes.
    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_SINGULAR = 2'd1;
    localparam logic [1:0] STATUS_SATURATED = 2'd2;

    typedef logic signed [NW-1:0] coef_t;
    typedef logic [MW-1:0] mag_t;

    // Control that travels with each word down the pipeline.
    typedef struct packed {
        logic valid;
        logic singular;
    } tpi_ctl_t;

endpackage

// File: rtl/tpi_front.sv
// Front end: cross products, triple product, numerators, magnitudes.
// Six register stages; depends on tpi_pkg.
module tpi_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  tpi_pkg::coef_t              n_in [3][3],
    input  tpi_pkg::coef_t              d_in [3],
    input  logic [tpi_pkg::LIMW-1:0]    limit,
    output tpi_pkg::tpi_ctl_t           ctl_out,
    output tpi_pkg::mag_t               den_mag,
    output tpi_pkg::mag_t               num_mag [3],
    output logic                        quo_neg [3]
);

    // Valid bits of the six stages.
    logic [tpi_pkg::FRONT_STAGES-1:0] vld_reg;

    // Stage 1: coefficient products.
    logic signed [tpi_pkg::PW-1:0] pa_reg [3][3];
    logic signed [tpi_pkg::PW-1:0] pb_reg [3][3];
    tpi_pkg::coef_t n0_s1_reg [3];
    tpi_pkg::coef_t d_s1_reg [3];

    // Stage 2: cross products (0 = n2 x n3, 1 = n3 x n1, 2 = n1 x n2).
    logic signed [tpi_pkg::CW-1:0] c_reg [3][3];
    tpi_pkg::coef_t n0_s2_reg [3];
    tpi_pkg::coef_t d_s2_reg [3];

    // Stage 3: split partial products; terms 0..2 denominator, 3.. numerators.
    logic signed [tpi_pkg::LPW-1:0] lo_reg [12];
    logic signed [tpi_pkg::PW-1:0] hi_reg [12];

    // Stage 4: recombined terms.
    logic signed [tpi_pkg::TW-1:0] term_reg [12];

    // Stage 5: sums.
    logic signed [tpi_pkg::SW-1:0] den_sum_reg;
    logic signed [tpi_pkg::SW-1:0] num_sum_reg [3];

    // Stage 6: magnitudes and flags.
    tpi_pkg::mag_t den_mag_reg;
    tpi_pkg::mag_t num_mag_reg [3];
    logic quo_neg_reg [3];
    logic singular_reg;

    logic [tpi_pkg::FRONT_STAGES-1:0] vld_next;

    assign vld_next = {vld_reg[tpi_pkg::FRONT_STAGES-2:0], in_valid};

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stages 1 and 2: the cross products of the plane normals.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pa_reg[j][k] <= n_in[(j + 1) % 3][(k + 1) % 3] * n_in[(j + 2) % 3][(k + 2) % 3];
                pb_reg[j][k] <= n_in[(j + 1) % 3][(k + 2) % 3] * n_in[(j + 2) % 3][(k + 1) % 3];
                c_reg[j][k] <= tpi_pkg::CW'(pa_reg[j][k]) - tpi_pkg::CW'(pb_reg[j][k]);
            end
            n0_s1_reg[j] <= n_in[0][j];
            d_s1_reg[j] <= d_in[j];
            n0_s2_reg[j] <= n0_s1_reg[j];
            d_s2_reg[j] <= d_s1_reg[j];
        end
    end

    // Stage 3: each wide product is cut into two narrow multiplies.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            lo_reg[k] <= n0_s2_reg[k] * $signed({1'b0, c_reg[0][k][tpi_pkg::LW-1:0]});
            hi_reg[k] <= n0_s2_reg[k] * $signed(c_reg[0][k][tpi_pkg::CW-1:tpi_pkg::LW]);
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[3 + 3 * k + i] <=
                    d_s2_reg[i] * $signed({1'b0, c_reg[i][k][tpi_pkg::LW-1:0]});
                hi_reg[3 + 3 * k + i] <=
                    d_s2_reg[i] * $signed(c_reg[i][k][tpi_pkg::CW-1:tpi_pkg::LW]);
            end
        end
    end

    // Stage 4: rejoin the two halves of every term.
    always_ff @(posedge clk)
    begin
        for (int t = 0; t < 12; t++)
        begin
            term_reg[t] <= $signed({hi_reg[t][tpi_pkg::TW-tpi_pkg::LW-1:0], {tpi_pkg::LW{1'b0}}})
                + $signed({{(tpi_pkg::TW-tpi_pkg::LPW){lo_reg[t][tpi_pkg::LPW-1]}}, lo_reg[t]});
        end
    end

    // Stage 5: triple product and numerator sums, kept exact.
    always_ff @(posedge clk)
    begin
        den_sum_reg <= tpi_pkg::SW'(term_reg[0]) + tpi_pkg::SW'(term_reg[1])
            + tpi_pkg::SW'(term_reg[2]);
        for (int k = 0; k < 3; k++)
        begin
            num_sum_reg[k] <= tpi_pkg::SW'(term_reg[3 + 3 * k])
                + tpi_pkg::SW'(term_reg[4 + 3 * k]) + tpi_pkg::SW'(term_reg[5 + 3 * k]);
        end
    end

    // Stage 6: magnitudes, quotient signs and the singular test.
    always_ff @(posedge clk)
    begin
        logic signed [tpi_pkg::SW-1:0] dabs;
        logic signed [tpi_pkg::SW-1:0] nabs;
        dabs = den_sum_reg[tpi_pkg::SW-1] ? -den_sum_reg : den_sum_reg;
        den_mag_reg <= dabs[tpi_pkg::MW-1:0];
        singular_reg <= (dabs[tpi_pkg::MW-1:0] == '0)
            || (dabs[tpi_pkg::MW-1:0] < tpi_pkg::MW'(limit));
        for (int k = 0; k < 3; k++)
        begin
            nabs = num_sum_reg[k][tpi_pkg::SW-1] ? -num_sum_reg[k] : num_sum_reg[k];
            num_mag_reg[k] <= nabs[tpi_pkg::MW-1:0];
            quo_neg_reg[k] <= num_sum_reg[k][tpi_pkg::SW-1] ^ den_sum_reg[tpi_pkg::SW-1];
        end
    end

    assign ctl_out.valid = vld_reg[tpi_pkg::FRONT_STAGES-1];
    assign ctl_out.singular = singular_reg;
    assign den_mag = den_mag_reg;
    assign num_mag = num_mag_reg;
    assign quo_neg = quo_neg_reg;

endmodule

// File: rtl/tpi_divider.sv
// Pipelined restoring divider, three lanes sharing one divisor, one bit a stage.
// Depends on tpi_pkg.
module tpi_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpi_pkg::tpi_ctl_t           ctl_in,
    input  tpi_pkg::mag_t               den_mag,
    input  tpi_pkg::mag_t               num_mag [3],
    input  logic                        quo_neg [3],
    output tpi_pkg::tpi_ctl_t           ctl_out,
    output logic [tpi_pkg::QW-1:0]      quo [3],
    output logic                        ovf [3],
    output logic                        neg [3]
);

    localparam int QW = tpi_pkg::QW;
    localparam int MW = tpi_pkg::MW;

    tpi_pkg::tpi_ctl_t ctl_reg [QW+1];
    tpi_pkg::mag_t den_reg [QW+1];
    tpi_pkg::mag_t rem_reg [QW+1][3];
    logic [QW-1:0] low_reg [QW+1][3];
    logic [QW-1:0] q_reg [QW+1][3];
    logic ovf_reg [QW+1][3];
    logic neg_reg [QW+1][3];

    // Entry stage: overflow precheck and the initial partial remainder.
    always_ff @(posedge clk)
    begin
        den_reg[0] <= den_mag;
        for (int l = 0; l < 3; l++)
        begin
            ovf_reg[0][l] <= MW'(num_mag[l] >> tpi_pkg::PRE_SHIFT) >= den_mag;
            rem_reg[0][l] <= MW'(num_mag[l] >> tpi_pkg::PRE_SHIFT);
            low_reg[0][l] <= {num_mag[l][tpi_pkg::PRE_SHIFT-1:0],
                {tpi_pkg::FRAC_SHIFT{1'b0}}};
            q_reg[0][l] <= '0;
            neg_reg[0][l] <= quo_neg[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
        end
    end

    // One quotient bit per stage.
    for (genvar s = 1; s <= QW; s++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            logic [MW:0] trial;
            logic ge;
            den_reg[s] <= den_reg[s-1];
            for (int l = 0; l < 3; l++)
            begin
                trial = {rem_reg[s-1][l], low_reg[s-1][l][QW-1]};
                ge = trial >= {1'b0, den_reg[s-1]};
                rem_reg[s][l] <= ge ? MW'(trial - {1'b0, den_reg[s-1]}) : trial[MW-1:0];
                q_reg[s][l] <= {q_reg[s-1][l][QW-2:0], ge};
                low_reg[s][l] <= {low_reg[s-1][l][QW-2:0], 1'b0};
                ovf_reg[s][l] <= ovf_reg[s-1][l];
                neg_reg[s][l] <= neg_reg[s-1][l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    assign ctl_out = ctl_reg[QW];
    assign quo = q_reg[QW];
    assign ovf = ovf_reg[QW];
    assign neg = neg_reg[QW];

endmodule

// File: rtl/three_plane_intersection.sv
// Top level of the three-plane intersection block (Cramer's rule, fixed point).
// Depends on tpi_pkg, tpi_front and tpi_divider.
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ---------------------------------------
//  input     start / busy           normal1..3_x/y/z, offset1..3 (Q11.12)
//  result    done (one-cycle pulse) point_x/y/z (Q15.16), status
//  config    cfg_write              cfg_data -> singular_limit
//
// A word is taken in every cycle; busy stays low, so a word is accepted
// whenever start is high. Each word then passes six stages of products and
// sums, a 34-stage pipelined divider (an entry stage, then one quotient bit
// per stage) and the output register. The receiver cannot stall. Reset clears
// all valid bits and loads the singular limit with 69.
module three_plane_intersection (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [23:0]          normal1_x,
    input  logic signed [23:0]          normal1_y,
    input  logic signed [23:0]          normal1_z,
    input  logic signed [23:0]          offset1,
    input  logic signed [23:0]          normal2_x,
    input  logic signed [23:0]          normal2_y,
    input  logic signed [23:0]          normal2_z,
    input  logic signed [23:0]          offset2,
    input  logic signed [23:0]          normal3_x,
    input  logic signed [23:0]          normal3_y,
    input  logic signed [23:0]          normal3_z,
    input  logic signed [23:0]          offset3,
    input  logic                        cfg_write,
    input  logic [31:0]                 cfg_data,
    output logic                        done,
    output logic signed [31:0]          point_x,
    output logic signed [31:0]          point_y,
    output logic signed [31:0]          point_z,
    output logic [1:0]                  status
);

    logic [tpi_pkg::LIMW-1:0] limit_reg;

    tpi_pkg::coef_t n_in [3][3];
    tpi_pkg::coef_t d_in [3];

    tpi_pkg::tpi_ctl_t front_ctl;
    tpi_pkg::mag_t den_mag;
    tpi_pkg::mag_t num_mag [3];
    logic quo_neg [3];

    tpi_pkg::tpi_ctl_t div_ctl;
    logic [tpi_pkg::QW-1:0] quo [3];
    logic ovf [3];
    logic neg [3];

    logic done_reg;
    logic [tpi_pkg::OW-1:0] point_reg [3];
    logic [1:0] status_reg;
    logic [tpi_pkg::OW-1:0] point_next [3];
    logic [1:0] status_next;

    assign busy = 1'b0;

    assign n_in[0][0] = normal1_x;
    assign n_in[0][1] = normal1_y;
    assign n_in[0][2] = normal1_z;
    assign n_in[1][0] = normal2_x;
    assign n_in[1][1] = normal2_y;
    assign n_in[1][2] = normal2_z;
    assign n_in[2][0] = normal3_x;
    assign n_in[2][1] = normal3_y;
    assign n_in[2][2] = normal3_z;
    assign d_in[0] = offset1;
    assign d_in[1] = offset2;
    assign d_in[2] = offset3;

    // Singular limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= tpi_pkg::LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            limit_reg <= cfg_data;
        end
    end

    tpi_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(start),
        .n_in    (n_in),
        .d_in    (d_in),
        .limit   (limit_reg),
        .ctl_out (front_ctl),
        .den_mag (den_mag),
        .num_mag (num_mag),
        .quo_neg (quo_neg)
    );

    tpi_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (front_ctl),
        .den_mag (den_mag),
        .num_mag (num_mag),
        .quo_neg (quo_neg),
        .ctl_out (div_ctl),
        .quo     (quo),
        .ovf     (ovf),
        .neg     (neg)
    );

    // Sign, saturation and the singular override.
    always_comb
    begin
        logic sat;
        sat = 1'b0;
        for (int l = 0; l < 3; l++)
        begin
            if (neg[l])
            begin
                if (ovf[l] || (quo[l] > tpi_pkg::QMAX_NEG))
                begin
                    point_next[l] = tpi_pkg::SAT_NEG;
                    sat = 1'b1;
                end
                else
                begin
                    point_next[l] = -quo[l][tpi_pkg::OW-1:0];
                end
            end
            else
            begin
                if (ovf[l] || (quo[l] > tpi_pkg::QMAX_POS))
                begin
                    point_next[l] = tpi_pkg::SAT_POS;
                    sat = 1'b1;
                end
                else
                begin
                    point_next[l] = quo[l][tpi_pkg::OW-1:0];
                end
            end
            if (div_ctl.singular)
            begin
                point_next[l] = '0;
            end
        end
        if (div_ctl.singular)
        begin
            status_next = tpi_pkg::STATUS_SINGULAR;
        end
        else if (sat)
        begin
            status_next = tpi_pkg::STATUS_SATURATED;
        end
        else
        begin
            status_next = tpi_pkg::STATUS_OK;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
        status_reg <= status_next;
    end

    assign done = done_reg;
    assign point_x = point_reg[0];
    assign point_y = point_reg[1];
    assign point_z = point_reg[2];
    assign status = status_reg;

endmodule

// File: rtl/tpi_checker.sv
// Port-level checks for three_plane_intersection, bound to the top level.
// Depends on tpi_pkg.
module tpi_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                done,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    input  logic [1:0]          status
);

    // Every result word stems from a word accepted a fixed time before.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, tpi_pkg::LATENCY))
        else $error("result word without an accepted input word");

    // A singular system reports the origin.
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == tpi_pkg::STATUS_SINGULAR)
            |-> (point_x == 0 && point_y == 0 && point_z == 0))
        else $error("singular result with nonzero point");

    // A saturated status shows at least one clipped coordinate.
    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == tpi_pkg::STATUS_SATURATED)
            |-> (point_x == tpi_pkg::SAT_POS || point_x == tpi_pkg::SAT_NEG
              || point_y == tpi_pkg::SAT_POS || point_y == tpi_pkg::SAT_NEG
              || point_z == tpi_pkg::SAT_POS || point_z == tpi_pkg::SAT_NEG))
        else $error("saturated status without a clipped coordinate");

    // Status codes stay within the defined set.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == tpi_pkg::STATUS_OK || status == tpi_pkg::STATUS_SINGULAR
            || status == tpi_pkg::STATUS_SATURATED))
        else $error("undefined status code");

endmodule

bind three_plane_intersection tpi_checker u_tpi_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .point_x (point_x),
    .point_y (point_y),
    .point_z (point_z),
    .status  (status)
);

// File: tb/three_plane_intersection_tb.sv
// Testbench for three_plane_intersection: directed and random plane triples.
// Checks each result word against an in-bench Cramer's rule predictor.
// Depends on tpi_pkg and the three_plane_intersection RTL.
`timescale 1ns / 100ps

module three_plane_intersection_tb;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        tpi_pkg::coef_t n[3][3];
        tpi_pkg::coef_t d[3];
    } planes_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         st;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    tpi_pkg::coef_t n1x = '0, n1y = '0, n1z = '0, d1 = '0;
    tpi_pkg::coef_t n2x = '0, n2y = '0, n2z = '0, d2 = '0;
    tpi_pkg::coef_t n3x = '0, n3y = '0, n3z = '0, d3 = '0;
    logic cfg_write = 1'b0;
    logic [31:0] cfg_data = '0;
    logic done;
    logic signed [31:0] point_x, point_y, point_z;
    logic [1:0] status;

    logic [31:0] limit_model = tpi_pkg::LIMIT_RESET;
    point_t pending_points[$];
    int idle_pct = 0;
    bit failed = 1'b0;
    int cycles = 0;

    three_plane_intersection uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .normal1_x(n1x), .normal1_y(n1y), .normal1_z(n1z), .offset1(d1),
        .normal2_x(n2x), .normal2_y(n2y), .normal2_z(n2z), .offset2(d2),
        .normal3_x(n3x), .normal3_y(n3y), .normal3_z(n3z), .offset3(d3),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .done(done), .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .status(status)
    );

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Exact intersection point; only the final division rounds toward zero.
    function automatic point_t solve_planes(planes_t p, logic [31:0] lim);
        logic signed [127:0] n[3][3];
        logic signed [127:0] d[3];
        logic signed [127:0] c23[3], c31[3], c12[3];
        logic signed [127:0] den, mag, num, q, lim_w;
        logic signed [31:0] c[3];
        point_t r;
        bit sat;
        int a, b;
        sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
                n[i][k] = p.n[i][k];
            d[i] = p.d[i];
        end
        for (int k = 0; k < 3; k++)
        begin
            a = (k + 1) % 3;
            b = (k + 2) % 3;
            c23[k] = n[1][a] * n[2][b] - n[1][b] * n[2][a];
            c31[k] = n[2][a] * n[0][b] - n[2][b] * n[0][a];
            c12[k] = n[0][a] * n[1][b] - n[0][b] * n[1][a];
        end
        den = n[0][0] * c23[0] + n[0][1] * c23[1] + n[0][2] * c23[2];
        mag = (den < 0) ? -den : den;
        lim_w = $signed({96'd0, lim});
        if (mag == 0 || mag < lim_w)
        begin
            r.x = '0;
            r.y = '0;
            r.z = '0;
            r.st = tpi_pkg::STATUS_SINGULAR;
            return r;
        end
        for (int k = 0; k < 3; k++)
        begin
            num = d[0] * c23[k] + d[1] * c31[k] + d[2] * c12[k];
            q = (num <<< 16) / den;
            if (q > 128'sd2147483647)
            begin
                c[k] = tpi_pkg::SAT_POS;
                sat = 1'b1;
            end
            else if (q < -128'sd2147483648)
            begin
                c[k] = tpi_pkg::SAT_NEG;
                sat = 1'b1;
            end
            else
                c[k] = q[31:0];
        end
        r.x = c[0];
        r.y = c[1];
        r.z = c[2];
        r.st = sat ? tpi_pkg::STATUS_SATURATED : tpi_pkg::STATUS_OK;
        return r;
    endfunction

    // Drive one word and hold it until accepted, then maybe idle.
    task automatic send_planes(planes_t p);
        start <= 1'b1;
        n1x <= p.n[0][0]; n1y <= p.n[0][1]; n1z <= p.n[0][2]; d1 <= p.d[0];
        n2x <= p.n[1][0]; n2y <= p.n[1][1]; n2z <= p.n[1][2]; d2 <= p.d[1];
        n3x <= p.n[2][0]; n3y <= p.n[2][1]; n3z <= p.n[2][2]; d3 <= p.d[2];
        do @(posedge clk); while (busy);
        pending_points.push_back(solve_planes(p, limit_model));
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Stop sending and let the pipeline empty completely.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (tpi_pkg::LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_limit(logic [31:0] v);
        drain_pipeline();
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        limit_model = v;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Diagonal normals k*I with offsets dv: the determinant is k^3.
    function automatic planes_t diag_planes(tpi_pkg::coef_t k, tpi_pkg::coef_t dv0,
                                            tpi_pkg::coef_t dv1, tpi_pkg::coef_t dv2);
        planes_t p;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p.n[i][j] = (i == j) ? k : tpi_pkg::coef_t'(0);
        p.d[0] = dv0;
        p.d[1] = dv1;
        p.d[2] = dv2;
        return p;
    endfunction

    // Random coefficient, sign-extended from the given number of bits.
    function automatic tpi_pkg::coef_t rand_coef(int bits);
        logic [23:0] v;
        logic [23:0] half;
        v = 24'($urandom);
        if (bits < 24)
        begin
            half = 24'd1 << (bits - 1);
            v = ((v & ((half << 1) - 24'd1)) ^ half) - half;
        end
        return tpi_pkg::coef_t'(v);
    endfunction

    // Random triple: full range, small, near-singular or diagonal-like.
    function automatic planes_t rand_planes();
        planes_t p;
        int kind, bits;
        kind = $urandom_range(9);
        bits = (kind < 4) ? 24 : $urandom_range(4, 14);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                p.n[i][j] = rand_coef(bits);
            p.d[i] = rand_coef($urandom_range(1) ? 24 : bits);
        end
        if (kind >= 7)
        begin
            // Third plane close to the sum of the first two.
            for (int j = 0; j < 3; j++)
                p.n[2][j] = p.n[0][j] + p.n[1][j]
                    + tpi_pkg::coef_t'($urandom_range(6)) - 24'sd3;
        end
        else if (kind == 6)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    if (i != j && $urandom_range(1))
                        p.n[i][j] = '0;
        end
        return p;
    endfunction

    // Result checker: every done word must match the oldest prediction.
    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && done)
        begin
            if (pending_points.size() == 0)
            begin
                $error("result word with no prediction waiting");
                failed = 1'b1;
            end
            else
            begin
                e = pending_points.pop_front();
                if (point_x !== e.x)
                begin
                    $error("point_x expected %0d actual %0d", e.x, point_x);
                    failed = 1'b1;
                end
                if (point_y !== e.y)
                begin
                    $error("point_y expected %0d actual %0d", e.y, point_y);
                    failed = 1'b1;
                end
                if (point_z !== e.z)
                begin
                    $error("point_z expected %0d actual %0d", e.z, point_z);
                    failed = 1'b1;
                end
                if (status !== e.st)
                begin
                    $error("status expected %0d actual %0d", e.st, status);
                    failed = 1'b1;
                end
            end
        end
    end

    // Field extremes, degenerate normals and the reset limit boundary.
    task automatic test_directed_reset_limit();
        planes_t p;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                p.n[i][j] = '0;
            p.d[i] = '0;
        end
        send_planes(p);
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                p.n[i][j] = 24'sh800000;
            p.d[i] = 24'sh7FFFFF;
        end
        send_planes(p);
        send_planes(diag_planes(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh000001));
        send_planes(diag_planes(24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh000000));
        send_planes(diag_planes(24'sh001000, 24'sh7FFFFF, 24'sh800000, 24'sh001234));
        send_planes(diag_planes(24'sd4, 24'sd100, 24'sd100, 24'sd100));
        send_planes(diag_planes(24'sd5, 24'sd100, -24'sd100, 24'sd7));
        send_planes(diag_planes(24'sd16, 24'sh7FFFFF, 24'sh800000, 24'sd1));
        p = diag_planes(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
        p.n[0][1] = 24'sh800000;
        p.n[1][2] = 24'sh800000;
        p.n[2][0] = 24'sh7FFFFF;
        send_planes(p);
    endtask

    // Zero limit still rejects a zero determinant; tiny determinants with large offsets saturate.
    task automatic test_zero_limit();
        write_limit(32'd0);
        send_planes(diag_planes(24'sd0, 24'sd5, 24'sd5, 24'sd5));
        send_planes(diag_planes(24'sd1, 24'sh7FFFFF, 24'sh800000, 24'sd3));
        send_planes(diag_planes(-24'sd1, 24'sh7FFFFF, 24'sh800000, 24'sd0));
        send_planes(diag_planes(24'sd1, 24'sd0, 24'sd1, -24'sd1));
    endtask

    // Determinant at and just under the limit, also under and above the all-ones limit.
    task automatic test_limit_boundary();
        write_limit(32'd125);
        send_planes(diag_planes(24'sd5, 24'sd9, 24'sd9, 24'sd9));
        send_planes(diag_planes(-24'sd5, 24'sd9, 24'sd9, 24'sd9));
        write_limit(32'd126);
        send_planes(diag_planes(24'sd5, 24'sd9, 24'sd9, 24'sd9));
        write_limit(32'hFFFF_FFFF);
        send_planes(diag_planes(24'sd1625, 24'sd9, 24'sd9, 24'sd9));
        send_planes(diag_planes(24'sd2048, 24'sh7FFFFF, 24'sd9, 24'sh800000));
    endtask

    task automatic test_random(int count, int pct, logic [31:0] lim);
        write_limit(lim);
        idle_pct = pct;
        for (int i = 0; i < count; i++)
            send_planes(rand_planes());
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_reset_limit();
        test_zero_limit();
        test_limit_boundary();
        test_random(650, 8, tpi_pkg::LIMIT_RESET);
        test_random(450, 87, $urandom_range(1 << 20));
        test_random(400, 0, $urandom);
        test_random(400, 8, 32'd1);
        drain_pipeline();
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
